>>> hw/rtl/cap_pkg.sv
// Shared types and constants for the call-arc and PC-sample profiler.
`timescale 1ns / 1ps
`default_nettype none

package cap_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PC_W   = 28;
  localparam int unsigned RIDX_W = 14;
  localparam int unsigned CIDX_W = 2;

  localparam int unsigned TABLE_ENTRIES_DEF    = 16384;
  localparam int unsigned BYTES_PER_BUCKET_DEF = 4;

  typedef enum logic [1:0] {
    REQ_CALL    = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_RD_ARC  = 2'd2,
    REQ_RD_HIST = 2'd3
  } req_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PROF_ON   = 2'd0,
    CFG_TEXT_LOW  = 2'd1,
    CFG_TEXT_HIGH = 2'd2,
    CFG_LOAD_OFS  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic            prof_on;
    logic [PC_W-1:0] text_low;
    logic [PC_W-1:0] text_high;
    logic [PC_W-1:0] load_ofs;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic calc;
    logic win;
    logic mul;
    logic div;
    logic rd;
    logic wr;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/cap_dp.sv
// Profiler datapath: address math, bucket divide, table memories, output register.
`timescale 1ns / 1ps
`default_nettype none

module cap_dp #(
  parameter int unsigned TABLE_ENTRIES    = cap_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned BYTES_PER_BUCKET = cap_pkg::BYTES_PER_BUCKET_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cap_pkg::cfg_t                cfg_i,
  input  cap_pkg::cmd_t                cmd_i,
  output cap_pkg::sts_t                sts_o,
  input  logic [1:0]                   req_type_i,
  input  logic [cap_pkg::DATA_W-1:0]   caller_pc_i,
  input  logic [cap_pkg::DATA_W-1:0]   callee_pc_i,
  input  logic [cap_pkg::RIDX_W-1:0]   read_index_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic                         recorded_o,
  output logic [cap_pkg::DATA_W-1:0]   entry_caller_o,
  output logic [cap_pkg::DATA_W-1:0]   entry_callee_o,
  output logic [cap_pkg::DATA_W-1:0]   entry_count_o
);
  import cap_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned DIV_W  = $clog2(BYTES_PER_BUCKET + 1);
  localparam int unsigned MUL_W  = PC_W + 1;
  localparam int unsigned PROD_W = PC_W + MUL_W;
  localparam int unsigned REM_W  = PC_W + DIV_W;
  // floor(2^PC_W / d): quotient estimate is exact or one low
  localparam logic [MUL_W-1:0]  RECIP   = MUL_W'((64'd1 << PC_W) / BYTES_PER_BUCKET);
  localparam logic [DIV_W-1:0]  DIVISOR = DIV_W'(BYTES_PER_BUCKET);
  localparam logic [DATA_W-1:0] DEPTH   = DATA_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]  LAST    = IDX_W'(TABLE_ENTRIES - 1);

  req_e               req_q;
  logic [DATA_W-1:0]  caller_q, callee_q;
  logic [RIDX_W-1:0]  ridx_q;
  logic [DATA_W-1:0]  addr_q, self_q, last_q;
  logic               in_win_q, hit_q;
  logic [PC_W-1:0]    off_q, bkt_q;
  logic [PROD_W-1:0]  prod_q;
  logic [IDX_W-1:0]   clr_q;

  logic [3*DATA_W-1:0] arc_mem [TABLE_ENTRIES];
  logic [DATA_W-1:0]   hist_mem [TABLE_ENTRIES];
  logic [3*DATA_W-1:0] arc_rd_q;
  logic [DATA_W-1:0]   hist_rd_q;

  logic                out_valid_q, rec_q;
  logic [DATA_W-1:0]   ocaller_q, ocallee_q, ocount_q;

  logic                is_read, in_win, rec, arc_we, hist_we;
  logic [DATA_W-1:0]   addr_d, self_d, ridx_ext;
  logic [PC_W-1:0]     q0, bkt_d;
  logic [REM_W-1:0]    rem;
  logic [IDX_W-1:0]    raddr, waddr;
  logic [3*DATA_W-1:0] arc_wdata;
  logic [DATA_W-1:0]   hist_wdata;
  logic [DATA_W-1:0]   res_caller, res_callee, res_count;

  assign is_read  = (req_q == REQ_RD_ARC) || (req_q == REQ_RD_HIST);
  assign ridx_ext = DATA_W'(ridx_q);

  // relocated runtime addresses, 32-bit wrap
  assign self_d = DATA_W'(callee_q[PC_W-1:0]) - DATA_W'(cfg_i.load_ofs);
  assign addr_d = (req_q == REQ_CALL)
                ? DATA_W'(caller_q[PC_W-1:0]) - DATA_W'(cfg_i.load_ofs)
                : last_q;

  assign in_win = (addr_q >= DATA_W'(cfg_i.text_low)) && (addr_q < DATA_W'(cfg_i.text_high));

  // quotient correction
  assign q0    = prod_q[PC_W +: PC_W];
  assign rem   = REM_W'(off_q) - REM_W'(q0) * REM_W'(DIVISOR);
  assign bkt_d = (rem >= REM_W'(DIVISOR)) ? q0 + PC_W'(1) : q0;

  assign raddr = is_read ? ridx_ext[IDX_W-1:0] : bkt_q[IDX_W-1:0];
  assign waddr = cmd_i.clr_en ? clr_q : bkt_q[IDX_W-1:0];

  assign rec = cfg_i.prof_on && in_win_q && hit_q &&
               ((req_q == REQ_CALL) || (req_q == REQ_TICK));

  assign arc_we     = cmd_i.clr_en || (cmd_i.wr && rec && (req_q == REQ_CALL));
  assign hist_we    = cmd_i.clr_en || (cmd_i.wr && rec && (req_q == REQ_TICK));
  assign arc_wdata  = cmd_i.clr_en ? '0
                    : {addr_q, self_q, arc_rd_q[DATA_W-1:0] + DATA_W'(1)};
  assign hist_wdata = cmd_i.clr_en ? '0 : hist_rd_q + DATA_W'(1);

  always_comb begin
    res_caller = '0;
    res_callee = '0;
    res_count  = '0;
    case (req_q)
      REQ_RD_ARC: begin
        if (hit_q) begin
          res_caller = arc_rd_q[2*DATA_W +: DATA_W];
          res_callee = arc_rd_q[DATA_W +: DATA_W];
          res_count  = arc_rd_q[DATA_W-1:0];
        end
      end
      REQ_RD_HIST: begin
        if (hit_q) begin
          res_count = hist_rd_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_e'(req_type_i);
      caller_q <= caller_pc_i;
      callee_q <= callee_pc_i;
      ridx_q   <= read_index_i;
    end
    if (cmd_i.calc) begin
      addr_q <= addr_d;
      self_q <= self_d;
    end
    if (cmd_i.win) begin
      in_win_q <= in_win;
      off_q    <= addr_q[PC_W-1:0] - cfg_i.text_low;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(off_q) * PROD_W'(RECIP);
    end
    if (cmd_i.div) begin
      bkt_q <= bkt_d;
    end
    if (cmd_i.rd) begin
      hit_q <= is_read ? (ridx_ext < DEPTH) : (DATA_W'(bkt_q) < DEPTH);
    end
  end

  // last PC and clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.win && (req_q == REQ_CALL) && cfg_i.prof_on && in_win) begin
        last_q <= self_q;
      end
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + IDX_W'(1);
      end
    end
  end

  // arc table: {caller, callee, count}
  always_ff @(posedge clk_i) begin
    if (arc_we) begin
      arc_mem[waddr] <= arc_wdata;
    end
    if (cmd_i.rd) begin
      arc_rd_q <= arc_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[waddr] <= hist_wdata;
    end
    if (cmd_i.rd) begin
      hist_rd_q <= hist_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rec_q     <= rec;
      ocaller_q <= res_caller;
      ocallee_q <= res_callee;
      ocount_q  <= res_count;
    end
  end

  assign sts_o.clr_last = (clr_q == LAST);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign recorded_o     = rec_q;
  assign entry_caller_o = ocaller_q;
  assign entry_callee_o = ocallee_q;
  assign entry_count_o  = ocount_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_rec_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && recorded_o) |->
      (entry_caller_o == '0 && entry_callee_o == '0 && entry_count_o == '0))
    else $error("recorded beat carries read data");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_en |-> (!cmd_i.wr && !cmd_i.out_load && !cmd_i.load))
    else $error("item activity during table clear");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/cap_ctrl.sv
// Profiler controller: clear sweep after reset, then one item at a time through the stages.
`timescale 1ns / 1ps
`default_nettype none

module cap_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cap_pkg::sts_t sts_i,
  output cap_pkg::cmd_t cmd_o
);
  import cap_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WIN,
    ST_MUL,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_HOLD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_WIN;
      end
      ST_WIN: begin
        cmd_o.win = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        // table write happens once here; the result may wait in HOLD
        cmd_o.wr       = 1'b1;
        cmd_o.out_load = sts_i.out_free;
        state_d        = sts_i.out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        cmd_o.out_load = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef SYNTH
  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CALC))
    else $error("accepted beat did not start processing");

  a_one_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.calc, cmd_o.win, cmd_o.mul, cmd_o.div, cmd_o.rd, cmd_o.wr}))
    else $error("more than one stage active");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/call_arc_and_pc_sample_profiler.sv
// Top level of the call-arc and PC-sample profiler: config registers, controller, datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------------
//   in      | in        | in_valid_i / in_stall_o   | req_type, caller_pc, callee_pc, read_index
//   out     | out       | out_valid_o / out_stall_i | recorded, entry_caller/callee/count
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each item passes in turn through accept, address relocation, window check, reciprocal
// multiply, quotient correction, table read and table write/result; the bucket divide and
// the read-modify-write of the table memory set these steps.
// After reset a clear pass writes zero to every table entry with in_stall_o high; config
// writes are taken meanwhile.
// A finished result waits in the output register under out_stall_i while the next item
// is accepted.
`timescale 1ns / 1ps
`default_nettype none

module call_arc_and_pc_sample_profiler #(
  parameter int unsigned TABLE_ENTRIES    = cap_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned BYTES_PER_BUCKET = cap_pkg::BYTES_PER_BUCKET_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [cap_pkg::DATA_W-1:0] caller_pc_i,
  input  logic [cap_pkg::DATA_W-1:0] callee_pc_i,
  input  logic [cap_pkg::RIDX_W-1:0] read_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       recorded_o,
  output logic [cap_pkg::DATA_W-1:0] entry_caller_o,
  output logic [cap_pkg::DATA_W-1:0] entry_callee_o,
  output logic [cap_pkg::DATA_W-1:0] entry_count_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cap_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [cap_pkg::PC_W-1:0]   cfg_data_i
);
  import cap_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prof_on   <= 1'b1;
      cfg_q.text_low  <= '0;
      cfg_q.text_high <= '0;
      cfg_q.load_ofs  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PROF_ON:   cfg_q.prof_on   <= cfg_data_i[0];
        CFG_TEXT_LOW:  cfg_q.text_low  <= cfg_data_i;
        CFG_TEXT_HIGH: cfg_q.text_high <= cfg_data_i;
        CFG_LOAD_OFS:  cfg_q.load_ofs  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cap_dp #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .BYTES_PER_BUCKET (BYTES_PER_BUCKET)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_type_i),
    .caller_pc_i    (caller_pc_i),
    .callee_pc_i    (callee_pc_i),
    .read_index_i   (read_index_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .recorded_o     (recorded_o),
    .entry_caller_o (entry_caller_o),
    .entry_callee_o (entry_callee_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the call-arc and PC-sample profiler top level.
`timescale 1ns / 1ps

module tb;
  import cap_pkg::*;

  localparam int unsigned TBL      = TABLE_ENTRIES_DEF;
  localparam int unsigned BPB      = BYTES_PER_BUCKET_DEF;
  localparam logic [31:0] PC_MASK  = 32'h0FFF_FFFF;
  localparam int unsigned LIMIT_NS = 12_000_000;

  typedef struct packed {
    logic        rec;
    logic [31:0] caller;
    logic [31:0] callee;
    logic [31:0] count;
  } prof_result_t;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    cfg_idx_e     idx;
    logic [27:0]  data;
    req_e         req;
    logic [31:0]  caller;
    logic [31:0]  callee;
    logic [13:0]  ridx;
    bit           typed;
    prof_result_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [31:0] caller_pc_i;
  logic [31:0] callee_pc_i;
  logic [13:0] read_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        recorded_o;
  logic [31:0] entry_caller_o;
  logic [31:0] entry_callee_o;
  logic [31:0] entry_count_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [27:0] cfg_data_i;

  // predictor state
  logic [31:0] m_arc_caller [TBL];
  logic [31:0] m_arc_callee [TBL];
  logic [31:0] m_arc_count  [TBL];
  logic [31:0] m_hist       [TBL];
  logic [31:0] m_last_pc;
  logic        m_prof_on;
  logic [31:0] m_text_low;
  logic [31:0] m_text_high;
  logic [31:0] m_load_ofs;

  prof_result_t pending_results[$];
  logic [13:0]  arc_seen[$];
  logic [13:0]  bin_seen[$];
  dir_row_t     dir_rows[$];

  int unsigned errors;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int          hold_left;
  int unsigned n_calls, n_ticks, n_reads, n_recorded, n_settings;

  call_arc_and_pc_sample_profiler u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .caller_pc_i    (caller_pc_i),
    .callee_pc_i    (callee_pc_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .recorded_o     (recorded_o),
    .entry_caller_o (entry_caller_o),
    .entry_callee_o (entry_callee_o),
    .entry_count_o  (entry_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns MISMATCH: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %08h want %08h", name, got, want));
    end
  endtask

  function automatic bit in_text(input logic [31:0] addr);
    return addr >= m_text_low && addr < m_text_high;
  endfunction

  function automatic logic [31:0] bucket_of(input logic [31:0] addr);
    return (addr - m_text_low) / BPB;
  endfunction

  // Updates the profile tables and returns what the block should report.
  function automatic prof_result_t predict_profile(input req_e req, input logic [31:0] caller,
                                                   input logic [31:0] callee,
                                                   input logic [13:0] ridx);
    prof_result_t r;
    logic [31:0]  caller_rel, callee_rel, slot;
    r = '0;
    case (req)
      REQ_CALL: begin
        caller_rel = (caller & PC_MASK) - m_load_ofs;
        callee_rel = (callee & PC_MASK) - m_load_ofs;
        if (m_prof_on && in_text(caller_rel)) begin
          slot = bucket_of(caller_rel);
          m_last_pc = callee_rel;
          if (slot < TBL) begin
            m_arc_caller[slot[13:0]] = caller_rel;
            m_arc_callee[slot[13:0]] = callee_rel;
            m_arc_count[slot[13:0]]  = m_arc_count[slot[13:0]] + 32'd1;
            r.rec = 1'b1;
          end
        end
      end
      REQ_TICK: begin
        slot = bucket_of(m_last_pc);
        if (m_prof_on && in_text(m_last_pc) && slot < TBL) begin
          m_hist[slot[13:0]] = m_hist[slot[13:0]] + 32'd1;
          r.rec = 1'b1;
        end
      end
      REQ_RD_ARC: begin
        r.caller = m_arc_caller[ridx];
        r.callee = m_arc_callee[ridx];
        r.count  = m_arc_count[ridx];
      end
      default: r.count = m_hist[ridx];
    endcase
    return r;
  endfunction

  function automatic dir_row_t mk_reg(input cfg_idx_e idx, input logic [27:0] data);
    dir_row_t row;
    row = '{ROW_CFG, idx, data, REQ_CALL, '0, '0, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t mk_beat(input req_e req, input logic [31:0] caller,
                                       input logic [31:0] callee, input logic [13:0] ridx);
    dir_row_t row;
    row = '{ROW_ITEM, CFG_PROF_ON, '0, req, caller, callee, ridx, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t mk_known(input req_e req, input logic [31:0] caller,
                                        input logic [31:0] callee, input logic [13:0] ridx,
                                        input logic rec, input logic [31:0] ec,
                                        input logic [31:0] ee, input logic [31:0] en);
    dir_row_t row;
    row = mk_beat(req, caller, callee, ridx);
    row.typed      = 1'b1;
    row.res.rec    = rec;
    row.res.caller = ec;
    row.res.callee = ee;
    row.res.count  = en;
    return row;
  endfunction

  // receiver side: random stalls, or a long counted hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    prof_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("recorded", {31'd0, recorded_o}, {31'd0, want.rec});
        check_field("entry_caller", entry_caller_o, want.caller);
        check_field("entry_callee", entry_callee_o, want.callee);
        check_field("entry_count", entry_count_o, want.count);
        if (recorded_o === 1'b1) begin
          n_recorded++;
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [27:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_PROF_ON:   m_prof_on   = data[0];
      CFG_TEXT_LOW:  m_text_low  = {4'd0, data};
      CFG_TEXT_HIGH: m_text_high = {4'd0, data};
      default:       m_load_ofs  = {4'd0, data};
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drop valid and let every outstanding result drain, plus pipeline slack
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic send_beat(input req_e req, input logic [31:0] caller, input logic [31:0] callee,
                           input logic [13:0] ridx, input bit typed, input prof_result_t known);
    prof_result_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    caller_pc_i  <= caller;
    callee_pc_i  <= callee;
    read_index_i <= ridx;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    want = predict_profile(req, caller, callee, ridx);
    pending_results.push_back(typed ? known : want);
    case (req)
      REQ_CALL: n_calls++;
      REQ_TICK: n_ticks++;
      default:  n_reads++;
    endcase
  endtask

  // Calls that land in the window lead the mix (so ticks and reads find data), some noise.
  task automatic send_random_beat();
    logic [31:0] caller, callee, rel, off, slot, span;
    logic [13:0] ridx;
    req_e        req;
    int unsigned pick;
    span   = (m_text_high > m_text_low) ? m_text_high - m_text_low : 32'd1;
    pick   = $urandom_range(99);
    caller = $urandom;
    callee = $urandom;
    ridx   = 14'($urandom_range(TBL - 1));
    req    = REQ_CALL;
    if (pick < 45) begin
      rel    = m_text_low + $urandom_range(span - 1);
      off    = rel + m_load_ofs;
      caller = {caller[31:28], off[27:0]};
      slot   = (rel - m_text_low) / BPB;
      if (slot < TBL) arc_seen.push_back(slot[13:0]);
      if ($urandom_range(9) < 8) begin
        rel    = m_text_low + $urandom_range(span - 1);
        off    = rel + m_load_ofs;
        callee = {callee[31:28], off[27:0]};
        slot   = (rel - m_text_low) / BPB;
        if (slot < TBL) bin_seen.push_back(slot[13:0]);
      end
    end else if (pick < 60) begin
      req = REQ_TICK;
    end else if (pick < 72) begin
      req = REQ_RD_ARC;
      if (arc_seen.size() != 0 && $urandom_range(4) != 0) begin
        ridx = arc_seen[$urandom_range(arc_seen.size() - 1)];
      end
    end else if (pick < 84) begin
      req = REQ_RD_HIST;
      if (bin_seen.size() != 0 && $urandom_range(4) != 0) begin
        ridx = bin_seen[$urandom_range(bin_seen.size() - 1)];
      end
    end else begin
      req = req_e'($urandom_range(3));
    end
    if (arc_seen.size() > 64) void'(arc_seen.pop_front());
    if (bin_seen.size() > 64) void'(bin_seen.pop_front());
    send_beat(req, caller, callee, ridx, 1'b0, '0);
  endtask

  task automatic run_phase(input logic prof, input logic [27:0] low, input logic [27:0] high,
                           input logic [27:0] ofs, input int unsigned snd,
                           input int unsigned stl, input int n, input int hold_at,
                           input int pause_at);
    int i;
    wait_idle();
    write_reg(CFG_PROF_ON, {27'd0, prof});
    write_reg(CFG_TEXT_LOW, low);
    write_reg(CFG_TEXT_HIGH, high);
    write_reg(CFG_LOAD_OFS, ofs);
    send_idle_pct = snd;
    stall_pct     = stl;
    n_settings++;
    arc_seen.delete();
    bin_seen.delete();
    for (i = 0; i < n; i++) begin
      if (i == hold_at) hold_left = 300;
      if (i == pause_at) wait_idle();
      send_random_beat();
    end
  endtask

  initial begin : stimulus
    logic [27:0] low_a, ofs_a;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_CALL;
    caller_pc_i   = '0;
    callee_pc_i   = '0;
    read_index_i  = '0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_PROF_ON;
    cfg_data_i    = '0;
    errors        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    foreach (m_hist[k]) begin
      m_arc_caller[k] = '0;
      m_arc_callee[k] = '0;
      m_arc_count[k]  = '0;
      m_hist[k]       = '0;
    end
    m_last_pc   = '0;
    m_prof_on   = 1'b1;
    m_text_low  = '0;
    m_text_high = '0;
    m_load_ofs  = '0;

    // register write lands during the clear pass; then reset state, empty window
    dir_rows.push_back(mk_reg(CFG_PROF_ON, 28'd1));
    dir_rows.push_back(mk_known(REQ_RD_ARC, '0, '0, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_RD_HIST, '1, '1, 14'h3FFF, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_CALL, '1, '1, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_TICK, '0, '0, 14'd0, 1'b0, '0, '0, '0));
    // window [0x1000, 0x2000): edges, masking of the top nibble
    dir_rows.push_back(mk_reg(CFG_TEXT_LOW, 28'h0001000));
    dir_rows.push_back(mk_reg(CFG_TEXT_HIGH, 28'h0002000));
    dir_rows.push_back(mk_reg(CFG_LOAD_OFS, 28'd0));
    dir_rows.push_back(mk_known(REQ_CALL, 32'h1000, 32'h1800, 14'd0, 1'b1, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_CALL, 32'hF000_1FFC, '1, 14'd0, 1'b1, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_TICK, '0, '0, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_CALL, 32'h2000, 32'h1000, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_CALL, 32'h0FFF, 32'h1000, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_CALL, 32'h1004, 32'h1000, 14'd0, 1'b1, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_TICK, '0, '0, 14'd0, 1'b1, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_TICK, '0, '0, 14'd0, 1'b1, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_RD_HIST, '0, '0, 14'd0, 1'b0, '0, '0, 32'd2));
    dir_rows.push_back(mk_known(REQ_RD_ARC, '0, '0, 14'd0, 1'b0, 32'h1000, 32'h1800, 32'd1));
    dir_rows.push_back(mk_known(REQ_RD_ARC, '0, '0, 14'h3FF, 1'b0, 32'h1FFC, PC_MASK, 32'd1));
    // profiling off: calls and ticks ignored, reads still served
    dir_rows.push_back(mk_reg(CFG_PROF_ON, 28'd0));
    dir_rows.push_back(mk_known(REQ_CALL, 32'h1000, 32'h1004, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_TICK, '0, '0, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_RD_ARC, '0, '0, 14'd1, 1'b0, 32'h1004, 32'h1000, 32'd1));
    // largest offset and widest window: relocation wraps
    dir_rows.push_back(mk_reg(CFG_PROF_ON, 28'd1));
    dir_rows.push_back(mk_reg(CFG_LOAD_OFS, 28'hFFFFFFF));
    dir_rows.push_back(mk_reg(CFG_TEXT_LOW, 28'd0));
    dir_rows.push_back(mk_reg(CFG_TEXT_HIGH, 28'hFFFFFFF));
    dir_rows.push_back(mk_beat(REQ_CALL, 32'h0FFF_FFFF, 32'h3, 14'd0));
    dir_rows.push_back(mk_beat(REQ_CALL, 32'h0, 32'h0, 14'd0));
    // bucket index past the table: last PC still moves, nothing recorded
    dir_rows.push_back(mk_reg(CFG_LOAD_OFS, 28'd0));
    dir_rows.push_back(mk_known(REQ_CALL, 32'h1_0000, 32'h2_0000, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_known(REQ_TICK, '0, '0, 14'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(mk_beat(REQ_CALL, 32'hFFFC, 32'hFFFF, 14'd0));
    dir_rows.push_back(mk_beat(REQ_TICK, '0, '0, 14'd0));
    dir_rows.push_back(mk_beat(REQ_RD_HIST, '0, '0, 14'h3FFF));
    dir_rows.push_back(mk_beat(REQ_RD_ARC, '0, '0, 14'h3FFF));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[k].idx, dir_rows[k].data);
      end else begin
        send_beat(dir_rows[k].req, dir_rows[k].caller, dir_rows[k].callee, dir_rows[k].ridx,
                  dir_rows[k].typed, dir_rows[k].res);
      end
    end

    low_a = 28'($urandom_range(28'h07F0_0000));
    ofs_a = 28'($urandom_range(28'h07FF_FFFF));
    // long receiver hold-off in the first phase fills the block
    run_phase(1'b1, low_a, low_a + 28'h8000, 28'd0, 0, 0, 150, 40, -1);
    // window wider than the table reaches past the last bucket
    run_phase(1'b1, low_a, low_a + 28'h10400, ofs_a, 73, 0, 150, -1, -1);
    run_phase(1'b1, 28'hFFF8000, 28'hFFFFFFF, 28'd0, 0, 73, 150, -1, -1);
    low_a = 28'($urandom_range(28'h07F0_0000));
    ofs_a = 28'($urandom_range(28'h07FF_FFFF));
    run_phase(1'b1, low_a, low_a + 28'h2000, ofs_a, 16, 16, 150, -1, 75);
    run_phase(1'b0, low_a, low_a + 28'h2000, ofs_a, 0, 73, 30, -1, -1);
    // inverted window records nothing
    run_phase(1'b1, 28'h0005000, 28'h0004000, 28'd0, 16, 16, 30, -1, -1);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results still outstanding at end of run");
    end
    $display("Ran %0d calls, %0d ticks and %0d reads; %0d updates seen, %0d mismatches.",
             n_calls, n_ticks, n_reads, n_recorded, errors);
    $display("Covered %0d random register settings plus directed edge cases and stall mixes.",
             n_settings);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cap_pkg.sv
hw/rtl/cap_dp.sv
hw/rtl/cap_ctrl.sv
hw/rtl/call_arc_and_pc_sample_profiler.sv
verif/tb.sv
